// File: src/fmrb_pkg.sv
package fmrb_pkg;

  localparam int unsigned RING_BYTES_DEF  = 1024;
  localparam int unsigned MAX_MESSAGE_DEF = 64;

  // Request codes, shared by req_type and answer_kind.
  localparam logic [1:0] REQ_BEGIN = 2'd0;
  localparam logic [1:0] REQ_BYTE  = 2'd1;
  localparam logic [1:0] REQ_GET   = 2'd2;
  localparam logic [1:0] REQ_DROPS = 2'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic [6:0] msg_length;
    logic [7:0] data_byte;
  } fmrb_in_t;

  typedef struct packed {
    logic [1:0]  answer_kind;
    logic        accepted;
    logic [7:0]  out_byte;
    logic [6:0]  out_length;
    logic        is_last;
    logic        is_empty;
    logic [31:0] drop_count;
  } fmrb_out_t;

endpackage

// File: src/fmrb_front.sv
module fmrb_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  fmrb_pkg::fmrb_in_t in_beat,
  output logic             q_valid,
  input  logic             q_pop,
  output fmrb_pkg::fmrb_in_t q_beat
);
  import fmrb_pkg::*;

  // Two-entry request queue between the front and the back.
  fmrb_in_t   mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push;

  assign full    = cnt_r[1];
  assign do_push = push && !full;
  assign q_valid = (cnt_r != 2'd0);
  assign q_beat  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ do_push;
    rp_nxt  = rp_r ^ q_pop;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= in_beat;
    end
  end
endmodule

// File: src/fmrb_back.sv
module fmrb_back #(
  parameter int unsigned RING_BYTES  = fmrb_pkg::RING_BYTES_DEF,
  parameter int unsigned MAX_MESSAGE = fmrb_pkg::MAX_MESSAGE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_pop,
  input  fmrb_pkg::fmrb_in_t  q_beat,
  output logic                empty,
  input  logic                pop,
  output fmrb_pkg::fmrb_out_t out_beat
);
  import fmrb_pkg::*;

  localparam int AW = $clog2(RING_BYTES);
  localparam int LIM = (MAX_MESSAGE < 64) ? MAX_MESSAGE : 64;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LEN  = 4'b0010,
    ST_DAT  = 4'b0100,
    ST_WAIT = 4'b1000
  } st_t;

  logic [7:0]    mem_r [RING_BYTES];
  logic [7:0]    rd_r;
  st_t           st_r, st_nxt;
  logic [AW-1:0] commit_r, commit_nxt, wpos_r, wpos_nxt, rpos_r, rpos_nxt;
  logic [6:0]    pend_r, pend_nxt, mlen_r, mlen_nxt, idx_r, idx_nxt;
  logic          disc_r, disc_nxt;
  logic [31:0]   drops_r, drops_nxt;
  logic          ovalid_r, ovalid_nxt;
  fmrb_out_t     obeat_r, obeat_nxt;
  logic          ofree;
  logic [AW:0]   free_b, used_b;
  logic [7:0]    clen;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;

  assign ofree    = !ovalid_r || pop;
  assign empty    = !ovalid_r;
  assign out_beat = obeat_r;

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
    nxt = (p == AW'(RING_BYTES - 1)) ? '0 : p + AW'(1);
  endfunction

  // Free space after abandoning any partial message.
  always_comb begin
    if (rpos_r > commit_r) begin
      used_b = (AW+1)'(RING_BYTES) - {1'b0, rpos_r} + {1'b0, commit_r};
    end else begin
      used_b = {1'b0, commit_r} - {1'b0, rpos_r};
    end
    free_b = (AW+1)'(RING_BYTES) - used_b;
    clen   = (rd_r > 8'(LIM)) ? 8'(LIM) : rd_r;
  end

  // Request handling and read-out sequencing.
  always_comb begin
    st_nxt     = st_r;
    commit_nxt = commit_r;
    wpos_nxt   = wpos_r;
    rpos_nxt   = rpos_r;
    pend_nxt   = pend_r;
    mlen_nxt   = mlen_r;
    idx_nxt    = idx_r;
    disc_nxt   = disc_r;
    drops_nxt  = drops_r;
    ovalid_nxt = ovalid_r && !pop;
    obeat_nxt  = obeat_r;
    q_pop      = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = wpos_r;
    mem_wdata  = q_beat.data_byte;
    case (st_r)
      ST_IDLE: begin
        if (q_valid && ofree) begin
          q_pop = 1'b1;
          obeat_nxt = '0;
          obeat_nxt.answer_kind = q_beat.req_type;
          case (q_beat.req_type)
            REQ_BEGIN: begin
              ovalid_nxt = 1'b1;
              if (q_beat.msg_length > 7'(LIM) ||
                  {{(AW-6){1'b0}}, q_beat.msg_length} + (AW+1)'(2) > free_b) begin
                if (drops_r != 32'hFFFF_FFFF) drops_nxt = drops_r + 32'd1;
                disc_nxt = 1'b1;
                pend_nxt = '0;
                wpos_nxt = commit_r;
              end else begin
                mem_we    = 1'b1;
                mem_addr  = commit_r;
                mem_wdata = {1'b0, q_beat.msg_length};
                disc_nxt  = 1'b0;
                pend_nxt  = q_beat.msg_length;
                wpos_nxt  = nxt(commit_r);
                if (q_beat.msg_length == 7'd0) commit_nxt = nxt(commit_r);
                obeat_nxt.accepted = 1'b1;
              end
            end
            REQ_BYTE: begin
              if (!disc_r && pend_r != 7'd0) begin
                mem_we   = 1'b1;
                wpos_nxt = nxt(wpos_r);
                pend_nxt = pend_r - 7'd1;
                if (pend_r == 7'd1) commit_nxt = nxt(wpos_r);
              end
            end
            REQ_GET: begin
              if (rpos_r == commit_r) begin
                ovalid_nxt = 1'b1;
                obeat_nxt.is_last = 1'b1;
                obeat_nxt.is_empty = 1'b1;
              end else begin
                st_nxt = ST_LEN;
              end
            end
            REQ_DROPS: begin
              ovalid_nxt = 1'b1;
              obeat_nxt.drop_count = drops_r;
              drops_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      ST_LEN: begin
        // Length byte is in rd_r; step past it.
        if (clen == 8'd0) begin
          if (ofree) begin
            rpos_nxt = nxt(rpos_r);
            ovalid_nxt = 1'b1;
            obeat_nxt = '0;
            obeat_nxt.answer_kind = REQ_GET;
            obeat_nxt.is_last = 1'b1;
            st_nxt = ST_IDLE;
          end
        end else begin
          rpos_nxt = nxt(rpos_r);
          mlen_nxt = clen[6:0];
          idx_nxt  = '0;
          st_nxt   = ST_WAIT;
        end
      end
      // The ring read of the next payload byte settles here.
      ST_WAIT: st_nxt = ST_DAT;
      ST_DAT: begin
        if (ofree) begin
          ovalid_nxt = 1'b1;
          obeat_nxt = '0;
          obeat_nxt.answer_kind = REQ_GET;
          obeat_nxt.out_byte = rd_r;
          obeat_nxt.out_length = mlen_r;
          obeat_nxt.is_last = (idx_r + 7'd1 == mlen_r);
          idx_nxt = idx_r + 7'd1;
          if (rpos_r != commit_r) rpos_nxt = nxt(rpos_r);
          st_nxt = (idx_r + 7'd1 == mlen_r) ? ST_IDLE : ST_WAIT;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Ring memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_addr] <= mem_wdata;
    end
    rd_r <= mem_r[rpos_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      commit_r <= '0;
      wpos_r <= '0;
      rpos_r <= '0;
      pend_r <= '0;
      disc_r <= 1'b0;
      drops_r <= '0;
      ovalid_r <= 1'b0;
      obeat_r <= '0;
      mlen_r <= '0;
      idx_r <= '0;
    end else begin
      st_r <= st_nxt;
      commit_r <= commit_nxt;
      wpos_r <= wpos_nxt;
      rpos_r <= rpos_nxt;
      pend_r <= pend_nxt;
      disc_r <= disc_nxt;
      drops_r <= drops_nxt;
      ovalid_r <= ovalid_nxt;
      obeat_r <= obeat_nxt;
      mlen_r <= mlen_nxt;
      idx_r <= idx_nxt;
    end
  end
endmodule

// File: src/framed_message_ring_buffer_core.sv
// A begin, an empty get or a drop read is answered from the output register once
// the back takes its beat from the request queue. A get reads the length byte,
// then each payload byte in turn through the registered read of the byte ring
// (a zero-length message answers from its length byte). Message bytes, begins and
// drop reads are taken at one beat per cycle when idle and the output is free.
// Reset (rst_n low, synchronous) empties the ring and clears the drop count.
module framed_message_ring_buffer_core #(
  parameter int unsigned RING_BYTES  = fmrb_pkg::RING_BYTES_DEF,
  parameter int unsigned MAX_MESSAGE = fmrb_pkg::MAX_MESSAGE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  fmrb_pkg::fmrb_in_t  in_beat,
  output logic                empty,
  input  logic                pop,
  output fmrb_pkg::fmrb_out_t out_beat
);
  import fmrb_pkg::*;

  logic     q_valid, q_pop;
  fmrb_in_t q_beat;

  // Front: request queue.
  fmrb_front u_front (
    .clk, .rst_n, .push, .full, .in_beat,
    .q_valid, .q_pop, .q_beat
  );

  // Back: ring storage and read-out sequencer.
  fmrb_back #(.RING_BYTES(RING_BYTES), .MAX_MESSAGE(MAX_MESSAGE)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_beat, .empty, .pop, .out_beat
  );
endmodule

// File: src/fmrb_checker.sv
module fmrb_props (
  input logic                clk,
  input logic                rst_n,
  input logic                empty,
  input logic                pop,
  input fmrb_pkg::fmrb_out_t out_beat
);
  import fmrb_pkg::*;

  // A waiting result holds until popped.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_beat)) else $error("result changed");

  // Empty get result is always last.
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_beat.is_empty |-> out_beat.is_last) else $error("empty not last");

  // Only begin answers carry accepted.
  a_acc: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_beat.accepted |-> out_beat.answer_kind == REQ_BEGIN)
    else $error("bad accepted");

  // Nothing waits right after reset.
  a_rst: assert property (@(posedge clk) !rst_n |=> empty) else $error("reset");
endmodule

bind framed_message_ring_buffer_core fmrb_props u_chk (
  .clk, .rst_n, .empty, .pop, .out_beat
);

// File: bench/fmrb_checker.sv
// Watches both channels of the message ring, predicts every answer and
// compares each popped beat against the oldest prediction.
module fmrb_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic                full,
  input  fmrb_pkg::fmrb_in_t  in_beat,
  input  logic                empty,
  input  logic                pop,
  input  fmrb_pkg::fmrb_out_t out_beat,
  output int                  error_count,
  output int                  answers_waiting,
  output int                  answers_seen,
  output int                  drops_seen,
  output int                  messages_read
);
  import fmrb_pkg::*;

  localparam int RING = RING_BYTES_DEF;
  localparam int MAX_LEN = MAX_MESSAGE_DEF;

  // Shadow copy of the ring and its pointers.
  logic [7:0]  ring_mem [RING];
  logic [9:0]  commit_ptr;
  logic [9:0]  wr_ptr;
  logic [9:0]  rd_ptr;
  logic [6:0]  left_to_write;
  logic        skipping;
  logic [31:0] drop_tally;

  fmrb_out_t answer_queue[$];

  assign answers_waiting = answer_queue.size();

  function automatic fmrb_out_t blank_answer(logic [1:0] kind);
    fmrb_out_t a;
    a = '0;
    a.answer_kind = kind;
    return a;
  endfunction

  // Apply one accepted request to the shadow state and queue its answers.
  task automatic predict_answers(fmrb_in_t req);
    fmrb_out_t a;
    int free_space;
    int run_len;
    case (req.req_type)
      REQ_BEGIN: begin
        wr_ptr = commit_ptr;
        left_to_write = '0;
        skipping = 1'b0;
        if (rd_ptr > commit_ptr) free_space = rd_ptr - commit_ptr;
        else free_space = RING - (commit_ptr - rd_ptr);
        a = blank_answer(REQ_BEGIN);
        if (req.msg_length > MAX_LEN || req.msg_length + 2 > free_space) begin
          if (drop_tally != 32'hFFFF_FFFF) drop_tally = drop_tally + 1;
          skipping = 1'b1;
          drops_seen++;
        end else begin
          ring_mem[wr_ptr] = {1'b0, req.msg_length};
          wr_ptr = wr_ptr + 1;
          left_to_write = req.msg_length;
          if (req.msg_length == 0) commit_ptr = wr_ptr;
          a.accepted = 1'b1;
        end
        answer_queue.push_back(a);
      end
      REQ_BYTE: begin
        // Bytes outside an accepted message are ignored.
        if (!skipping && left_to_write != 0) begin
          ring_mem[wr_ptr] = req.data_byte;
          wr_ptr = wr_ptr + 1;
          left_to_write = left_to_write - 1;
          if (left_to_write == 0) commit_ptr = wr_ptr;
        end
      end
      REQ_GET: begin
        a = blank_answer(REQ_GET);
        a.is_last = 1'b1;
        if (rd_ptr == commit_ptr) begin
          a.is_empty = 1'b1;
          answer_queue.push_back(a);
        end else begin
          messages_read++;
          run_len = ring_mem[rd_ptr];
          rd_ptr = rd_ptr + 1;
          if (run_len > MAX_LEN) run_len = MAX_LEN;
          if (run_len == 0) begin
            answer_queue.push_back(a);
          end else begin
            for (int i = 0; i < run_len; i++) begin
              a = blank_answer(REQ_GET);
              a.out_byte = ring_mem[rd_ptr];
              a.out_length = run_len[6:0];
              a.is_last = (i + 1 == run_len);
              if (rd_ptr != commit_ptr) rd_ptr = rd_ptr + 1;
              answer_queue.push_back(a);
            end
          end
        end
      end
      default: begin
        a = blank_answer(REQ_DROPS);
        a.drop_count = drop_tally;
        drop_tally = '0;
        answer_queue.push_back(a);
      end
    endcase
  endtask

  task automatic flag_field(string name, longint unsigned want, longint unsigned got);
    $display("%0t: mismatch in %s: expected 0x%0h, actual 0x%0h", $time, name, want, got);
    error_count++;
  endtask

  // Compare one popped beat, field by field, with the oldest prediction.
  task automatic check_answer(fmrb_out_t got);
    fmrb_out_t want;
    answers_seen++;
    if (answer_queue.size() == 0) begin
      $display("%0t: unexpected beat 0x%0h with nothing predicted", $time, got);
      error_count++;
    end else begin
      want = answer_queue.pop_front();
      if (got.answer_kind !== want.answer_kind)
        flag_field("answer_kind", want.answer_kind, got.answer_kind);
      if (got.accepted !== want.accepted) flag_field("accepted", want.accepted, got.accepted);
      if (got.out_byte !== want.out_byte) flag_field("out_byte", want.out_byte, got.out_byte);
      if (got.out_length !== want.out_length)
        flag_field("out_length", want.out_length, got.out_length);
      if (got.is_last !== want.is_last) flag_field("is_last", want.is_last, got.is_last);
      if (got.is_empty !== want.is_empty) flag_field("is_empty", want.is_empty, got.is_empty);
      if (got.drop_count !== want.drop_count)
        flag_field("drop_count", want.drop_count, got.drop_count);
    end
  endtask

  initial begin
    error_count = 0;
    answers_seen = 0;
    drops_seen = 0;
    messages_read = 0;
    commit_ptr = '0;
    wr_ptr = '0;
    rd_ptr = '0;
    left_to_write = '0;
    skipping = 1'b0;
    drop_tally = '0;
  end

  // Sample both channels at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) predict_answers(in_beat);
      if (pop && !empty) check_answer(out_beat);
    end
  end

endmodule

// File: bench/testbench.sv
module testbench;
  import fmrb_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      push;
  logic      full;
  fmrb_in_t  in_beat;
  logic      empty;
  logic      pop;
  fmrb_out_t out_beat;
  int        error_count;
  int        answers_waiting;
  int        answers_seen;
  int        drops_seen;
  int        messages_read;
  int        burst_left;
  int        requests_sent;
  int        beats_sent;

  framed_message_ring_buffer_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_beat  (in_beat),
    .empty    (empty),
    .pop      (pop),
    .out_beat (out_beat)
  );

  fmrb_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_beat         (in_beat),
    .empty           (empty),
    .pop             (pop),
    .out_beat        (out_beat),
    .error_count     (error_count),
    .answers_waiting (answers_waiting),
    .answers_seen    (answers_seen),
    .drops_seen      (drops_seen),
    .messages_read   (messages_read)
  );

  // Clock with a 12 unit period.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Send one beat, hold it until taken, then idle between bursts.
  // Full only moves at the rising edge, so its value at the falling edge
  // tells whether the next rising edge takes the beat.
  task automatic send_beat(logic [1:0] kind, logic [6:0] len, logic [7:0] data);
    in_beat.req_type = kind;
    in_beat.msg_length = len;
    in_beat.data_byte = data;
    push = 1'b1;
    while (full) @(negedge clk);
    @(negedge clk);
    beats_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      push = 1'b0;
      in_beat = fmrb_in_t'($urandom);
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  // A begin followed by some of its payload bytes.
  task automatic send_message(logic [6:0] len, int bytes_to_send);
    send_beat(REQ_BEGIN, len, 8'($urandom));
    for (int i = 0; i < bytes_to_send; i++) send_beat(REQ_BYTE, 7'($urandom), 8'($urandom));
    requests_sent++;
  endtask

  task automatic send_request(logic [1:0] kind);
    send_beat(kind, 7'($urandom), 8'($urandom));
    requests_sent++;
  endtask

  // Receiver stalls follow one of three random patterns, which is picked anew in turn.
  initial begin
    int mode;
    pop = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      repeat (64) begin
        @(negedge clk);
        case (mode)
          0: pop = 1'b1;
          1: pop = $urandom_range(0, 1);
          default: pop = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    #(12 * 2000000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int pick;
    int len;
    push = 1'b0;
    in_beat = '0;
    rst_n = 1'b0;
    burst_left = 0;
    requests_sent = 0;
    beats_sent = 0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Directed: zero length, empty get, oversize begins, stray byte,
    // abandoned message, full-length message, drop counter reads.
    send_message(7'd0, 0);
    send_request(REQ_GET);
    send_request(REQ_GET);
    send_request(REQ_DROPS);
    send_message(7'd65, 0);
    send_message(7'd127, 2);
    send_request(REQ_DROPS);
    send_beat(REQ_BYTE, 7'd0, 8'hFF);
    send_beat(REQ_BEGIN, 7'd3, 8'h00);
    send_beat(REQ_BYTE, 7'd127, 8'h00);
    send_beat(REQ_BYTE, 7'd0, 8'hFF);
    send_beat(REQ_BYTE, 7'd85, 8'h5A);
    send_request(REQ_GET);
    send_message(7'd5, 2);
    send_message(7'd1, 1);
    send_request(REQ_GET);
    send_message(7'd64, 64);
    send_request(REQ_GET);
    send_request(REQ_DROPS);

    // Random traffic of short messages until the beat budget is spent.
    while (beats_sent < 125) begin
      pick = $urandom_range(0, 99);
      len = $urandom_range(0, 12);
      if (pick < 55) begin
        send_message(7'(len), len);
      end else if (pick < 63) begin
        send_message(7'(len), (len == 0) ? 0 : $urandom_range(0, len - 1));
      end else if (pick < 66) begin
        send_message(7'($urandom_range(65, 127)), $urandom_range(0, 3));
      end else if (pick < 69) begin
        send_request(REQ_BYTE);
      end else if (pick < 92) begin
        send_request(REQ_GET);
      end else begin
        send_request(REQ_DROPS);
      end
    end
    // Drain what is left.
    repeat (20) send_request(REQ_GET);
    send_request(REQ_DROPS);
    push = 1'b0;

    while (answers_waiting != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Covered %0d requests in %0d beats, %0d answer beats, %0d messages read, %0d dropped.",
             requests_sent, beats_sent, answers_seen, messages_read, drops_seen);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
